[design/gbp_pkg.sv]
// shared types, constants and helper functions of the two-bit gray bitmap packer
`default_nettype none
package gbp_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned DimW   = 13;  // config register width
  localparam int unsigned PosW   = 12;  // column / row counters
  localparam int unsigned CntW   = 6;   // byte index within one item
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'b1;

  localparam logic [CntW-1:0] HdrBytes  = 6'd40;
  localparam logic [31:0]     HdrLength = 32'h0000_0028;
  localparam logic [31:0]     PlaneCode = 32'd2;
  localparam logic [31:0]     HdrOffset = 32'd40;

  // bytes caused by one pixel, as captured at acceptance
  typedef struct packed {
    logic            hdr;       // header goes out first
    logic            pb_valid;  // one packed pixel byte
    logic [7:0]      pb;
    logic [1:0]      pads;      // zero bytes that pad the row
    logic            done;      // last pixel of the image
    logic [CntW-1:0] n;         // total byte count
  } item_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  // gray level divided by 85
  function automatic logic [1:0] quantise(input logic [7:0] p);
    logic [1:0] q;
    if (p == 8'd255) begin
      q = 2'd3;
    end else if (p >= 8'd170) begin
      q = 2'd2;
    end else if (p >= 8'd85) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return q;
  endfunction

  // byte k of the 40-byte header, dwords little-endian
  function automatic logic [7:0] hdr_byte(input logic [CntW-1:0] k,
                                          input logic [31:0] total,
                                          input logic [DimW-1:0] w,
                                          input logic [DimW-1:0] h);
    logic [31:0] dw;
    logic [31:0] sh;
    case (k[CntW-1:2])
      4'd0:    dw = total;
      4'd1:    dw = HdrLength;
      4'd2:    dw = {{(32-DimW){1'b0}}, w};
      4'd3:    dw = {{(32-DimW){1'b0}}, h};
      4'd6:    dw = PlaneCode;
      default: dw = '0;
    endcase
    sh = dw >> {k[1:0], 3'b000};
    return sh[7:0];
  endfunction

endpackage
`default_nettype wire

[design/gbp_plan.sv]
// pixel quantising, packing state and per-item byte plan
`default_nettype none
module gbp_plan (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic [7:0]              pixel_i,
  input  wire logic [gbp_pkg::DimW-1:0] w_i,
  input  wire logic [gbp_pkg::DimW-1:0] h_i,
  output gbp_pkg::item_t               item_o
);
  import gbp_pkg::*;

  logic [PosW-1:0] column_q, column_d, row_q, row_d;
  logic [5:0]      partial_q, partial_d;
  logic [1:0]      slot_q, slot_d, rbm_q, rbm_d;
  logic            hs_q, hs_d;

  logic [1:0]      v;
  logic [5:0]      shifted;
  logic            row_end, last_row;

  always_comb begin
    v        = quantise(pixel_i);
    shifted  = {4'b0000, v} << {slot_q, 1'b0};
    column_d = column_q;
    row_d    = row_q;
    partial_d = partial_q;
    slot_d   = slot_q;
    rbm_d    = rbm_q;
    hs_d     = 1'b1;
    item_o   = '0;
    item_o.hdr = !hs_q;

    if (slot_q == 2'd3) begin
      item_o.pb_valid = 1'b1;
      item_o.pb       = {v, partial_q};
      partial_d       = '0;
      slot_d          = '0;
      rbm_d           = rbm_q + 2'd1;
    end else begin
      partial_d = partial_q | shifted;
      slot_d    = slot_q + 2'd1;
    end

    row_end  = ({1'b0, column_q} + DimW'(1)) >= w_i;
    last_row = ({1'b0, row_q} + DimW'(1)) >= h_i;
    if (row_end) begin
      if (slot_d != 2'd0) begin
        item_o.pb_valid = 1'b1;
        item_o.pb       = {2'b00, partial_d};
        partial_d       = '0;
        slot_d          = '0;
        rbm_d           = rbm_d + 2'd1;
      end
      item_o.pads = 2'd0 - rbm_d;
      rbm_d       = '0;
      column_d    = '0;
      if (last_row) begin
        item_o.done = 1'b1;
        row_d       = '0;
        hs_d        = 1'b0;
      end else begin
        row_d = row_q + PosW'(1);
      end
    end else begin
      column_d = column_q + PosW'(1);
    end

    item_o.n = (item_o.hdr ? HdrBytes : '0) + CntW'(item_o.pb_valid)
             + CntW'(item_o.pads);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q  <= '0;
      row_q     <= '0;
      partial_q <= '0;
      slot_q    <= '0;
      rbm_q     <= '0;
      hs_q      <= 1'b0;
    end else if (accept_i) begin
      column_q  <= column_d;
      row_q     <= row_d;
      partial_q <= partial_d;
      slot_q    <= slot_d;
      rbm_q     <= rbm_d;
      hs_q      <= hs_d;
    end
  end

endmodule
`default_nettype wire

[design/gbp_emit.sv]
// item register, byte sequencer and output register
`default_nettype none
module gbp_emit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire gbp_pkg::item_t          item_i,
  input  wire logic [31:0]             total_i,
  input  wire logic [gbp_pkg::DimW-1:0] w_i,
  input  wire logic [gbp_pkg::DimW-1:0] h_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         last_o,
  output logic                         image_done_o
);
  import gbp_pkg::*;

  item_t           item_q;
  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic            ov_q;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, done_q;

  logic            load, is_last, finishing;
  logic [CntW-1:0] j;

  assign load      = busy_q && (item_q.n != '0) && (!ov_q || out_ready_i);
  assign is_last   = (cnt_q == item_q.n - CntW'(1));
  assign finishing = busy_q && ((item_q.n == '0) || (load && is_last));
  assign free_o    = !busy_q || finishing;

  always_comb begin
    j = item_q.hdr ? (cnt_q - HdrBytes) : cnt_q;
    if (item_q.hdr && (cnt_q < HdrBytes)) begin
      byte_d = hdr_byte(cnt_q, total_i, w_i, h_i);
    end else if ((j == '0) && item_q.pb_valid) begin
      byte_d = item_q.pb;
    end else begin
      byte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (accept_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (finishing) begin
        busy_q <= 1'b0;
      end else if (load) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    if (load) begin
      byte_q <= byte_d;
      last_q <= is_last;
      done_q <= is_last && item_q.done;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = byte_q;
  assign last_o       = last_q;
  assign image_done_o = done_q;

endmodule
`default_nettype wire

[design/gray2_bitmap_packer_core.sv]
// top level of the two-bit gray bitmap packer
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  pixel   | in        | in_valid_i/in_ready_o | pixel_i
//  bytes   | out       | out_valid_o/out_ready_i | out_byte_o, last_o, image_done_o
//  config  | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one output byte per cycle unless out_ready_i stalls it, set by the single output
// register; a pixel that causes no byte still passes through the item register
// the first pixel of an image produces 40 header bytes ahead of its own bytes
// row-end pixels produce up to four bytes (flushed byte plus padding)
// a new pixel is taken in the cycle the last byte of the current one is loaded
// reset clears the packing state; config registers reset to 1 x 1
`default_nettype none
module gray2_bitmap_packer_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [gbp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [gbp_pkg::DimW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  pixel_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       out_byte_o,
  output logic                             last_o,
  output logic                             image_done_o
);
  import gbp_pkg::*;

  logic [DimW-1:0] width_q, height_q;
  logic [DimW-1:0] w, h;
  logic [DimW-1:0] wp3;
  logic [10:0]     rb;            // padded row bytes
  logic [23:0]     prod;
  logic [31:0]     total;
  logic            accept, free;
  item_t           item;

  // configuration registers, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // out-of-range sizes are clamped
  assign w = clamp_dim(width_q, DimW'(MaxWidth));
  assign h = clamp_dim(height_q, DimW'(MaxHeight));

  // bytes per row: quarter of the width rounded up, then to a dword
  assign wp3   = w + DimW'(3);
  assign rb    = (11'(wp3[DimW-1:2]) + 11'd3) & ~11'd3;
  assign prod  = 24'(h) * 24'(rb);
  assign total = HdrOffset + 32'(prod);

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  gbp_plan u_plan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .pixel_i  (pixel_i),
    .w_i      (w),
    .h_i      (h),
    .item_o   (item)
  );

  gbp_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item),
    .total_i      (total),
    .w_i          (w),
    .h_i          (h),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .image_done_o (image_done_o)
  );

endmodule
`default_nettype wire
